@@ rtl/core/signed_int_to_decimal_ascii_defines.svh @@
// Assertion macros for the checker of the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SIDIA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SIDIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/sidia_pkg.sv @@
// Package: constants, control struct and sizing helper for the decimal text converter.
package sidia_pkg;

   localparam int unsigned VALUE_WIDTH_DEF = 32;
   localparam int unsigned CODE_W          = 6;
   localparam int unsigned BCD_W           = 4;

   localparam logic [CODE_W-1:0] CODE_ZERO  = 6'd48;
   localparam logic [CODE_W-1:0] CODE_MINUS = 6'd45;
   localparam logic [CODE_W-1:0] CODE_NINE  = 6'd57;

   // Decimal digits needed for 2^(w-1): floor(w * log10(2)) + 1, at most one spare.
   function automatic int unsigned dec_digits(input int unsigned w);
      return (w * 30103) / 100000 + 1;
   endfunction

   // Commands to the BCD shift register.
   typedef struct packed {
      logic clear;        // zero every digit
      logic dabble;       // add-3 correction, then shift one binary bit in
      logic bit_in;       // binary bit shifted in with dabble
      logic digit_shift;  // move one whole digit towards the top
   } bcd_ctrl_type;

endpackage

@@ rtl/core/sidia_if.sv @@
// Valid/ready channel interfaces for requests (integers) and responses (characters).
interface sidia_req_if #(
   parameter int unsigned VALUE_WIDTH = sidia_pkg::VALUE_WIDTH_DEF
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sidia_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sidia_pkg::CODE_W-1:0]  char_code;
   logic                          is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

@@ rtl/core/sidia_bcd.sv @@
// BCD shift register: double-dabble conversion one bit a cycle, then digit-wise unload.
module sidia_bcd #(
   parameter int unsigned NUM_DIGITS = sidia_pkg::dec_digits(sidia_pkg::VALUE_WIDTH_DEF)
) (
   input  logic                          clock,
   input  sidia_pkg::bcd_ctrl_type       ctrl,
   output logic [sidia_pkg::BCD_W-1:0]   top_digit
);
   import sidia_pkg::*;

   logic [NUM_DIGITS-1:0][BCD_W-1:0] bcd_ff;
   logic [NUM_DIGITS-1:0][BCD_W-1:0] bcd_in;
   logic [NUM_DIGITS-1:0][BCD_W-1:0] adj;

   // add-3 on every digit of 5 or more, all digits in parallel
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= BCD_W'(5)) ? bcd_ff[i] + BCD_W'(3) : bcd_ff[i];
      end
   end

   always_comb begin
      bcd_in = bcd_ff;
      if (ctrl.clear) begin
         bcd_in = '0;
      end else if (ctrl.dabble) begin
         bcd_in = (NUM_DIGITS*BCD_W)'({adj, ctrl.bit_in});
      end else if (ctrl.digit_shift) begin
         bcd_in = {bcd_ff[NUM_DIGITS-2:0], BCD_W'(0)};
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[NUM_DIGITS-1];

endmodule

@@ rtl/core/signed_int_to_decimal_ascii.sv @@
// Top level: signed integer to decimal ASCII text, bit-serial conversion.
//
// Usage notes
// - req_ch carries one signed integer (value, VALUE_WIDTH bits) per request;
//   a request is taken when valid and ready are both high. Only one request
//   is in work at a time: ready is high only while the converter is idle.
// - rsp_ch carries the text, one character per response, most significant
//   first: '-' for a negative value, then the digits without leading zeros
//   (zero gives a single '0'). is_last marks the final character.
// - Conversion: double dabble over all VALUE_WIDTH magnitude bits, one
//   magnitude bit per cycle through the BCD shift register. Unload: one
//   digit slot per step (leading zero slots are dropped), plus a minus sign.
// - The first character is offered only after the conversion is complete;
//   the first digit follows once the leading zero slots are dropped.
// - The most negative value is converted as the unsigned 2^(VALUE_WIDTH-1).
// - The response register holds its character while the receiver stalls;
//   unloading simply waits, and nothing is lost or repeated.
// - Synchronous reset returns the block to idle with no response pending.
module signed_int_to_decimal_ascii #(
   parameter int unsigned VALUE_WIDTH = sidia_pkg::VALUE_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sidia_req_if.sink   req_ch,
   sidia_rsp_if.source rsp_ch
);
   import sidia_pkg::*;

   localparam int unsigned NumDigits = dec_digits(VALUE_WIDTH);
   localparam int unsigned CntW      = $clog2(VALUE_WIDTH + 1);
   localparam int unsigned DigW      = $clog2(NumDigits + 1);

   // state codes
   localparam logic [1:0] StIdle = 2'd0;   // waiting for a request
   localparam logic [1:0] StConv = 2'd1;   // shifting magnitude into BCD
   localparam logic [1:0] StEmit = 2'd2;   // unloading sign and digits

   logic [1:0]             state_ff,   state_in;
   logic [VALUE_WIDTH-1:0] mag_ff,     mag_in;      // magnitude, MSB shifted out first
   logic [CntW-1:0]        cnt_ff,     cnt_in;      // conversion bits left
   logic [DigW-1:0]        dig_ff,     dig_in;      // digit slots left to unload
   logic                   neg_ff,     neg_in;      // minus sign still to send
   logic                   started_ff, started_in;  // first significant digit sent
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]      code_ff,    code_in;
   logic                   last_ff,    last_in;

   bcd_ctrl_type           bcd_ctrl;
   logic [BCD_W-1:0]       top_digit;
   logic                   slot_free;

   sidia_bcd #(
      .NUM_DIGITS (NumDigits)
   ) u_bcd (
      .clock     (clock),
      .ctrl      (bcd_ctrl),
      .top_digit (top_digit)
   );

   // response register can take a new character this cycle
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      cnt_in       = cnt_ff;
      dig_in       = dig_ff;
      neg_in       = neg_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      code_in      = code_ff;
      last_in      = last_ff;
      bcd_ctrl     = '0;

      case (state_ff)
         StIdle: begin
            if (req_ch.valid) begin
               // two's complement magnitude; the most negative value wraps to 2^(W-1)
               mag_in   = req_ch.value[VALUE_WIDTH-1] ?
                          (~req_ch.value + VALUE_WIDTH'(1)) : req_ch.value;
               neg_in   = req_ch.value[VALUE_WIDTH-1];
               cnt_in   = CntW'(VALUE_WIDTH);
               bcd_ctrl.clear = 1'b1;
               state_in = StConv;
            end
         end
         StConv: begin
            bcd_ctrl.dabble = 1'b1;
            bcd_ctrl.bit_in = mag_ff[VALUE_WIDTH-1];
            mag_in = mag_ff << 1;
            cnt_in = cnt_ff - CntW'(1);
            if (cnt_ff == CntW'(1)) begin
               dig_in     = DigW'(NumDigits);
               started_in = 1'b0;
               state_in   = StEmit;
            end
         end
         StEmit: begin
            if (slot_free) begin
               if (neg_ff) begin
                  rsp_valid_in = 1'b1;
                  code_in      = CODE_MINUS;
                  last_in      = 1'b0;
                  neg_in       = 1'b0;
               end else if (!started_ff && top_digit == BCD_W'(0) && dig_ff != DigW'(1)) begin
                  // leading zero: drop it, keep the last slot so zero prints '0'
                  bcd_ctrl.digit_shift = 1'b1;
                  dig_in = dig_ff - DigW'(1);
               end else begin
                  rsp_valid_in = 1'b1;
                  code_in      = CODE_ZERO + CODE_W'(top_digit);
                  last_in      = (dig_ff == DigW'(1));
                  started_in   = 1'b1;
                  bcd_ctrl.digit_shift = 1'b1;
                  dig_in = dig_ff - DigW'(1);
                  if (dig_ff == DigW'(1)) begin
                     state_in = StIdle;
                  end
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
         neg_ff       <= 1'b0;
         started_ff   <= 1'b0;
         cnt_ff       <= '0;
         dig_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         neg_ff       <= neg_in;
         started_ff   <= started_in;
         cnt_ff       <= cnt_in;
         dig_ff       <= dig_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      code_ff <= code_in;
      last_ff <= last_in;
   end

   assign req_ch.ready     = (state_ff == StIdle);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.char_code = code_ff;
   assign rsp_ch.is_last   = last_ff;

endmodule

@@ rtl/core/sidia_checker.sv @@
// Port-level checker for the decimal text converter, bound to the top level.
`include "signed_int_to_decimal_ascii_defines.svh"

module sidia_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [sidia_pkg::CODE_W-1:0] rsp_char_code,
   input logic                         rsp_is_last
);
   import sidia_pkg::*;

   // a stalled response keeps its character
   `SIDIA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_char_code) && $stable(rsp_is_last), "response changed while stalled")

   // only minus sign or decimal digits leave the block
   `SIDIA_ASSERT_NOW(a_code_range, clock, reset, rsp_valid, rsp_char_code == CODE_MINUS || (rsp_char_code >= CODE_ZERO && rsp_char_code <= CODE_NINE), "character outside sign and digits")

   // a minus sign is never marked as the last character
   `SIDIA_ASSERT_NOW(a_minus_not_last, clock, reset, rsp_valid && rsp_char_code == CODE_MINUS, !rsp_is_last, "minus sign marked as last")

   // one request in work at a time
   `SIDIA_ASSERT_NEXT(a_single_req, clock, reset, req_valid && req_ready, !req_ready, "request taken while converting")

endmodule

bind signed_int_to_decimal_ascii sidia_checker u_sidia_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_char_code (rsp_ch.char_code),
   .rsp_is_last   (rsp_ch.is_last)
);
